// ----- src/pdc8_pkg.sv -----
// Shared types, constants and the CRC-8 step function for the packet deframer.
`default_nettype none
package pdc8_pkg;

	localparam int unsigned MAX_PAYLOAD = 1023;
	localparam int unsigned CNT_CAP = (MAX_PAYLOAD < 1023) ? MAX_PAYLOAD : 1023;
	localparam int unsigned POS_W = 11;
	localparam logic [POS_W-1:0] POS_SAT = '1;
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'h00;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned TDATA_W = 48;

	// Configuration register indexes.
	localparam logic [1:0] REG_HEADER = 2'd0;
	localparam logic [1:0] REG_VERSION = 2'd1;
	localparam logic [1:0] REG_FOOTER = 2'd2;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic       kind;
		logic       last_of_run;
		logic [9:0] payload_count;
		logic [7:0] message_id;
		logic [7:0] source_id;
		logic [7:0] dest_id;
		logic       length_ok;
		logic       crc_ok;
		logic       footer_ok;
		logic       version_ok;
		logic       header_ok;
		logic [7:0] payload_byte;
	} res_t;

	// Results produced by one accepted byte: cnt of them, r0 first.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	// One byte folded into CRC-8, MSB first, no reflection.
	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- src/pdc8_core.sv -----
// Frame parser: position tracking, CRC, field capture and result formation.
`default_nettype none
module pdc8_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [7:0]          cfg_data,
	input  wire logic                acc,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                end_of_frame,
	output pdc8_pkg::push_t          push
);
	import pdc8_pkg::*;

	logic [7:0]       header_q, version_q, footer_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       crc_q;
	logic [7:0]       d0_q, d1_q;
	logic [2:0][7:0]  ids_q;
	logic [1:0]       flags_q;

	logic [7:0]       crc_nxt;
	logic [1:0]       flags_nxt;
	logic [2:0][7:0]  ids_nxt;
	logic             pay_v;
	logic             long_enough;
	logic [POS_W-1:0] cnt_raw;
	logic [9:0]       cnt_sat;
	logic             len_ok;
	res_t             pay_r, stat_r;

	always_comb begin
		crc_nxt = (pos_q >= POS_W'(2)) ? crc8_fold(crc_q, d1_q) : crc_q;
		pay_v = pos_q >= POS_W'(7);

		flags_nxt = flags_q;
		ids_nxt = ids_q;
		case (pos_q)
			POS_W'(0): flags_nxt[0] = (rx_byte == header_q);
			POS_W'(1): flags_nxt[1] = (rx_byte == version_q);
			POS_W'(2): ids_nxt[0] = rx_byte;
			POS_W'(3): ids_nxt[1] = rx_byte;
			POS_W'(4): ids_nxt[2] = rx_byte;
			default: ;
		endcase

		long_enough = pos_q >= POS_W'(6);
		cnt_raw = pos_q - POS_W'(6);
		cnt_sat = '0;
		len_ok = 1'b0;
		if (long_enough) begin
			len_ok = (pos_q != POS_SAT) && (32'(cnt_raw) <= MAX_PAYLOAD);
			cnt_sat = (32'(cnt_raw) > CNT_CAP) ? 10'(CNT_CAP) : cnt_raw[9:0];
		end

		pay_r = '0;
		pay_r.kind = KIND_PAYLOAD;
		pay_r.last_of_run = !end_of_frame;
		pay_r.payload_byte = d1_q;

		stat_r = '0;
		stat_r.kind = KIND_STATUS;
		stat_r.last_of_run = 1'b1;
		stat_r.header_ok = flags_nxt[0];
		stat_r.version_ok = flags_nxt[1];
		stat_r.footer_ok = (rx_byte == footer_q);
		stat_r.crc_ok = long_enough && (crc_nxt == d0_q);
		stat_r.length_ok = len_ok;
		stat_r.dest_id = ids_nxt[0];
		stat_r.source_id = ids_nxt[1];
		stat_r.message_id = ids_nxt[2];
		stat_r.payload_count = cnt_sat;

		push.cnt = 2'd0;
		if (acc) begin
			push.cnt = 2'(pay_v) + 2'(end_of_frame);
		end
		push.r0 = pay_v ? pay_r : stat_r;
		push.r1 = stat_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			version_q <= '0;
			footer_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER: header_q <= cfg_data;
				REG_VERSION: version_q <= cfg_data;
				REG_FOOTER: footer_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
			d0_q <= '0;
			d1_q <= '0;
			ids_q <= '0;
			flags_q <= '0;
		end else if (acc) begin
			if (end_of_frame) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
				d0_q <= '0;
				d1_q <= '0;
				ids_q <= '0;
				flags_q <= '0;
			end else begin
				pos_q <= (pos_q != POS_SAT) ? pos_q + POS_W'(1) : POS_SAT;
				crc_q <= crc_nxt;
				d0_q <= rx_byte;
				d1_q <= d0_q;
				ids_q <= ids_nxt;
				flags_q <= flags_nxt;
			end
		end
	end

	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && end_of_frame |=> pos_q == '0 && crc_q == CRC_INIT && flags_q == '0)
		else $error("frame state not cleared after final byte");
	a_two_only_at_eof: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> acc && end_of_frame && push.r1.kind == KIND_STATUS)
		else $error("two results from a byte that does not end the frame");
	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !end_of_frame && pos_q != POS_SAT |=> pos_q == $past(pos_q) + POS_W'(1))
		else $error("byte position did not advance");

endmodule
`default_nettype wire

// ----- src/pdc8_queue.sv -----
// Result queue: takes up to two results a cycle, hands out one a cycle while the receiver is ready.
`default_nettype none
module pdc8_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  pdc8_pkg::push_t      push,
	output logic                 space,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output pdc8_pkg::res_t       out_res
);
	import pdc8_pkg::*;

	res_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q, rptr_q;
	logic [Q_PTR_W:0]   count_q;
	logic               pop;

	assign out_valid = count_q != '0;
	assign pop = out_valid && out_ready;
	assign out_res = mem_q[rptr_q];
	// Room for the worst case of two results from the next byte.
	assign space = count_q <= (Q_PTR_W+1)'(Q_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wptr_q + Q_PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			wptr_q <= wptr_q + Q_PTR_W'(push.cnt);
			if (pop) begin
				rptr_q <= rptr_q + Q_PTR_W'(1);
			end
			count_q <= count_q + (Q_PTR_W+1)'(push.cnt) - (Q_PTR_W+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> 32'(count_q) + 32'(push.cnt) <= Q_DEPTH + 32'(pop))
		else $error("result queue overflow");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> count_q == $past(count_q) + (Q_PTR_W+1)'($past(push.cnt))
			- (Q_PTR_W+1)'($past(pop)))
		else $error("queue fill count lost track");
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |=> out_valid)
		else $error("pushed result not presented");

endmodule
`default_nettype wire

// ----- src/packet_deframer_crc8_unit.sv -----
// Top level of the byte-serial packet deframer with CRC-8 check.
//
// Usage: frame bytes enter on the s_axis channel, one byte per request, with
// s_axis_tlast high on the footer byte. Frames are laid out as header,
// version, destination id, source id, message id, payload, CRC, footer.
// The m_axis channel carries results: tuser 0 is a payload byte, tuser 1 is
// the frame status (header, version, footer, CRC and length checks, the three
// ids and the payload count). m_axis_tlast marks the last result caused by
// one input byte. The cfg channel writes the expected header (index 0),
// version (index 1) and footer (index 2) values; it is always ready and
// should only be written while no frame is in progress.
// A payload byte is pushed into the result queue when the byte two places
// after it is accepted; the status result when the footer is accepted.
// Throughput: one byte per cycle while the queue has room, set by the
// combinational parse logic in front of a four-entry result queue. A footer
// that follows payload pushes two results.
// Reset clears the frame state, the queue and all three registers to zero.
// When the receiver stalls, results wait in the queue and s_axis_tready
// falls once fewer than two entries are free.
`default_nettype none
module packet_deframer_crc8_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
	input  wire logic                           s_axis_tlast,  // end_of_frame
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// [7:0] payload_byte, [8] header_ok, [9] version_ok, [10] footer_ok,
	// [11] crc_ok, [12] length_ok, [20:13] dest_id, [28:21] source_id,
	// [36:29] message_id, [46:37] payload_count, [47] zero
	output logic [pdc8_pkg::TDATA_W-1:0]        m_axis_tdata,
	output logic                                m_axis_tlast,  // last_of_run
	output logic                                m_axis_tuser,  // kind
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [7:0]                     cfg_data
);
	import pdc8_pkg::*;

	logic  acc;
	push_t push;
	res_t  res;

	assign cfg_ready = 1'b1;
	assign acc = s_axis_tvalid && s_axis_tready;

	pdc8_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.acc          (acc),
		.rx_byte      (s_axis_tdata),
		.end_of_frame (s_axis_tlast),
		.push         (push)
	);

	pdc8_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	// Results leave with the fields packed from the lowest bit up.
	assign m_axis_tdata = {1'b0, res.payload_count, res.message_id, res.source_id,
		res.dest_id, res.length_ok, res.crc_ok, res.footer_ok, res.version_ok,
		res.header_ok, res.payload_byte};
	assign m_axis_tlast = res.last_of_run;
	assign m_axis_tuser = res.kind;

endmodule
`default_nettype wire
